[rtl/bwmh_pkg.sv]
// Shared types and constants for the bootloader write-memory host block.
package bwmh_pkg;

   // Buffer geometry
   localparam int BUF_DEPTH = 256;
   localparam int BUF_AW    = $clog2(BUF_DEPTH);
   localparam int CNT_W     = BUF_AW + 1;

   // Largest block in bytes (4 to BUF_DEPTH)
   localparam logic [CNT_W-1:0] BLOCK_SIZE = CNT_W'(256);

   // Protocol bytes
   localparam logic [7:0] ACK_BYTE  = 8'h79;
   localparam logic [7:0] PAD_BYTE  = 8'hFF;
   localparam logic [7:0] CMD_BYTE0 = 8'h31;
   localparam logic [7:0] CMD_BYTE1 = 8'hCE;

   // Input item kinds
   localparam logic [2:0] KIND_START    = 3'd0;
   localparam logic [2:0] KIND_DATA     = 3'd1;
   localparam logic [2:0] KIND_END      = 3'd2;
   localparam logic [2:0] KIND_RX_BYTE  = 3'd3;
   localparam logic [2:0] KIND_TX_READY = 3'd4;

   // Result status codes
   localparam logic [2:0] STAT_IDLE       = 3'd0;
   localparam logic [2:0] STAT_BUSY       = 3'd1;
   localparam logic [2:0] STAT_DONE       = 3'd2;
   localparam logic [2:0] STAT_NACK       = 3'd3;
   localparam logic [2:0] STAT_UNEXPECTED = 3'd4;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_FILL,
      PH_CMD0,
      PH_CMD1,
      PH_ACK_CMD,
      PH_ADDR,
      PH_ACK_ADDR,
      PH_LEN,
      PH_DATA,
      PH_CSUM,
      PH_ACK_DATA,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] target_address;
      logic [7:0]  data_byte;
   } req_payload_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       want_data;
      logic [2:0] status;
   } rsp_payload_type;

   // Buffer access from the sequencer
   typedef struct packed {
      logic              wr_en;
      logic [BUF_AW-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [BUF_AW-1:0] rd_addr;
   } buf_req_type;

endpackage

[rtl/bootloader_write_memory_host.sv]
// Each result beat is registered and offered in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle; a held result does not block the next
//   request unless the result channel is stalled.
// The data pull reads the block buffer through a registered read port prefetched ahead.
// Reset (synchronous) clears control state; buffer contents stay undefined, no sweep.
module bootloader_write_memory_host
   import bwmh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            req_accept;
   buf_req_type     buf_req;
   logic [7:0]      rd_data;
   rsp_payload_type rsp_next;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   bwmh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req        (req_payload),
      .rd_data    (rd_data),
      .buf_req    (buf_req),
      .rsp_next   (rsp_next)
   );

   bwmh_buf u_buf (
      .clock   (clock),
      .buf_req (buf_req),
      .rd_data (rd_data)
   );

   // Result register
   assign rsp_valid_in = req_stall ? rsp_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[rtl/bwmh_buf.sv]
// Block buffer: single write port, one registered read port with write forwarding.
module bwmh_buf
   import bwmh_pkg::*;
(
   input  logic        clock,
   input  buf_req_type buf_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [BUF_DEPTH];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (buf_req.wr_en) begin
         mem[buf_req.wr_addr] <= buf_req.wr_data;
      end
   end

   // Read port; a same-cycle write to the read address is forwarded
   always_ff @(posedge clock) begin
      if (buf_req.wr_en && (buf_req.wr_addr == buf_req.rd_addr)) begin
         rd_data_ff <= buf_req.wr_data;
      end else begin
         rd_data_ff <= mem[buf_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bwmh_ctrl.sv]
// Exchange sequencer: phase, counters, address and checksum, buffer access.
module bwmh_ctrl
   import bwmh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_accept,
   input  req_payload_type req,
   input  logic [7:0]      rd_data,
   output buf_req_type     buf_req,
   output rsp_payload_type rsp_next
);

   phase_type        phase_ff,      phase_in;
   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   logic [CNT_W-1:0] raw_count_ff,  raw_count_in;
   logic [CNT_W-1:0] send_index_ff, send_index_in;
   logic [31:0]      address_ff,    address_in;
   logic [7:0]       xor_ff,        xor_in;
   logic             data_ended_ff, data_ended_in;

   logic             tx_valid;
   logic [7:0]       tx_byte;
   logic             unexpected;
   logic [CNT_W-1:0] fill_next;
   logic [CNT_W-1:0] index_next;
   logic [2:0]       cur_status;

   // Round a byte count up to a multiple of four
   function automatic logic [CNT_W-1:0] pad4(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] s;
      s = n + CNT_W'(3);
      return {s[CNT_W-1:2], 2'b00};
   endfunction

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         fill_count_ff <= '0;
         raw_count_ff  <= '0;
         send_index_ff <= '0;
         address_ff    <= '0;
         xor_ff        <= '0;
         data_ended_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         fill_count_ff <= fill_count_in;
         raw_count_ff  <= raw_count_in;
         send_index_ff <= send_index_in;
         address_ff    <= address_in;
         xor_ff        <= xor_in;
         data_ended_ff <= data_ended_in;
      end
   end

   assign fill_next  = fill_count_ff + CNT_W'(1);
   assign index_next = send_index_ff + CNT_W'(1);

   // Next state and result for the accepted beat
   always_comb begin
      phase_in      = phase_ff;
      fill_count_in = fill_count_ff;
      raw_count_in  = raw_count_ff;
      send_index_in = send_index_ff;
      address_in    = address_ff;
      xor_in        = xor_ff;
      data_ended_in = data_ended_ff;
      tx_valid      = 1'b0;
      tx_byte       = '0;
      unexpected    = 1'b0;
      buf_req.wr_en   = 1'b0;
      buf_req.wr_addr = fill_count_ff[BUF_AW-1:0];
      buf_req.wr_data = req.data_byte;

      if (req_accept) begin
         unique case (req.kind)
            KIND_START: begin
               address_in    = req.target_address;
               fill_count_in = '0;
               raw_count_in  = '0;
               send_index_in = '0;
               xor_in        = '0;
               data_ended_in = 1'b0;
               phase_in      = PH_FILL;
            end
            KIND_DATA: begin
               if (phase_ff == PH_FILL) begin
                  buf_req.wr_en = 1'b1;
                  raw_count_in  = fill_next;
                  fill_count_in = fill_next;
                  if (fill_next >= BLOCK_SIZE) begin
                     fill_count_in = pad4(fill_next);
                     phase_in      = PH_CMD0;
                  end
               end else begin
                  unexpected = 1'b1;
               end
            end
            KIND_END: begin
               if (phase_ff == PH_FILL) begin
                  if (fill_count_ff == '0) begin
                     phase_in = PH_DONE;
                  end else begin
                     data_ended_in = 1'b1;
                     fill_count_in = pad4(fill_count_ff);
                     phase_in      = PH_CMD0;
                  end
               end else begin
                  unexpected = 1'b1;
               end
            end
            KIND_RX_BYTE: begin
               if (phase_ff == PH_ACK_CMD || phase_ff == PH_ACK_ADDR ||
                   phase_ff == PH_ACK_DATA) begin
                  if (req.data_byte != ACK_BYTE) begin
                     phase_in = PH_ERROR;
                  end else if (phase_ff == PH_ACK_CMD) begin
                     send_index_in = '0;
                     xor_in        = '0;
                     phase_in      = PH_ADDR;
                  end else if (phase_ff == PH_ACK_ADDR) begin
                     phase_in = PH_LEN;
                  end else begin
                     address_in    = address_ff + 32'(fill_count_ff);
                     fill_count_in = '0;
                     raw_count_in  = '0;
                     send_index_in = '0;
                     phase_in      = data_ended_ff ? PH_DONE : PH_FILL;
                  end
               end else begin
                  unexpected = 1'b1;
               end
            end
            KIND_TX_READY: begin
               tx_valid = 1'b1;
               unique case (phase_ff)
                  PH_CMD0: begin
                     tx_byte  = CMD_BYTE0;
                     phase_in = PH_CMD1;
                  end
                  PH_CMD1: begin
                     tx_byte  = CMD_BYTE1;
                     phase_in = PH_ACK_CMD;
                  end
                  PH_ADDR: begin
                     if (send_index_ff < CNT_W'(4)) begin
                        unique case (send_index_ff[1:0])
                           2'd0:    tx_byte = address_ff[31:24];
                           2'd1:    tx_byte = address_ff[23:16];
                           2'd2:    tx_byte = address_ff[15:8];
                           default: tx_byte = address_ff[7:0];
                        endcase
                        xor_in        = xor_ff ^ tx_byte;
                        send_index_in = index_next;
                     end else begin
                        tx_byte  = xor_ff;
                        phase_in = PH_ACK_ADDR;
                     end
                  end
                  PH_LEN: begin
                     tx_byte       = 8'(fill_count_ff - CNT_W'(1));
                     xor_in        = tx_byte;
                     send_index_in = '0;
                     phase_in      = PH_DATA;
                  end
                  PH_DATA: begin
                     // bytes past the raw count are padding
                     tx_byte       = (send_index_ff < raw_count_ff) ? rd_data : PAD_BYTE;
                     xor_in        = xor_ff ^ tx_byte;
                     send_index_in = index_next;
                     if (index_next >= fill_count_ff) begin
                        phase_in = PH_CSUM;
                     end
                  end
                  PH_CSUM: begin
                     tx_byte  = xor_ff;
                     phase_in = PH_ACK_DATA;
                  end
                  default: begin
                     tx_valid = 1'b0;
                  end
               endcase
            end
            default: begin
               unexpected = 1'b1;
            end
         endcase
      end

      // prefetch the entry the next data pull will need
      buf_req.rd_addr = send_index_in[BUF_AW-1:0];
   end

   // Status after the beat
   always_comb begin
      unique case (phase_in)
         PH_IDLE:  cur_status = STAT_IDLE;
         PH_DONE:  cur_status = STAT_DONE;
         PH_ERROR: cur_status = STAT_NACK;
         default:  cur_status = STAT_BUSY;
      endcase
   end

   assign rsp_next.tx_valid  = tx_valid;
   assign rsp_next.tx_byte   = tx_byte;
   assign rsp_next.want_data = (phase_in == PH_FILL);
   assign rsp_next.status    = unexpected ? STAT_UNEXPECTED : cur_status;

   // Checks
   a_raw_le_fill: assert property (@(posedge clock) disable iff (reset)
      raw_count_ff <= fill_count_ff)
      else $error("raw count exceeds padded count");

   a_padded: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_FILL) |-> (fill_count_ff[1:0] == 2'b00))
      else $error("block size not a multiple of four after close");

   a_wr_in_fill: assert property (@(posedge clock) disable iff (reset)
      buf_req.wr_en |-> (phase_ff == PH_FILL && req.kind == KIND_DATA))
      else $error("buffer write outside fill");

   a_data_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (send_index_ff < fill_count_ff))
      else $error("data index past block end");

endmodule

[sim/bootloader_write_memory_host_tb.sv]
// Self-checking testbench for the bootloader write-memory host: directed and random beats.
module bootloader_write_memory_host_tb;
   import bwmh_pkg::*;

   localparam int ITEM_GOAL  = 1900;
   localparam int RUN_LIMIT  = 6_000_000;
   localparam int TAIL_WAIT  = 8;
   localparam int ADDR_BYTES = 4;
   localparam int BIG_MAX    = 2;
   localparam logic [2:0] KIND_RESERVED_MAX = 3'd7;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   bootloader_write_memory_host u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stimulus shaping and bookkeeping
   bit              idle_on = 1'b0;
   bit              noise_on = 1'b0;
   int              hold_left = 0;
   int              stall_left = 0;
   int              mismatch_count = 0;
   int              item_total = 0;
   int              abort_countdown = 0;
   int              big_blocks = 0;
   rsp_payload_type awaited_replies[$];
   rsp_payload_type want_reply;

   // Predicted host state
   logic [7:0]       host_buf [BUF_DEPTH];
   logic [CNT_W-1:0] host_fill;
   logic [31:0]      host_addr;
   phase_type        host_phase;
   logic [CNT_W-1:0] host_sidx;
   logic [7:0]       host_xor;
   logic             host_ended;

   // Short runs mostly, now and then a long one
   function automatic int run_length();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Pad to a word multiple and arm the command header
   function automatic void close_host_block();
      while (host_fill[1:0] != 2'd0 && host_fill < CNT_W'(BUF_DEPTH)) begin
         host_buf[host_fill[BUF_AW-1:0]] = PAD_BYTE;
         host_fill = host_fill + 1'b1;
      end
      host_phase = PH_CMD0;
   endfunction

   // Advance the predicted host by one request beat, return its reply
   function automatic rsp_payload_type predict_host_reply(input req_payload_type p);
      rsp_payload_type  r;
      logic             stray;
      logic [31:0]      shifted;
      logic [CNT_W-1:0] len_m1;
      r = '0;
      stray = 1'b0;
      case (p.kind)
         KIND_START: begin
            host_addr  = p.target_address;
            host_fill  = '0;
            host_sidx  = '0;
            host_xor   = '0;
            host_ended = 1'b0;
            host_phase = PH_FILL;
         end
         KIND_DATA: begin
            if (host_phase == PH_FILL) begin
               host_buf[host_fill[BUF_AW-1:0]] = p.data_byte;
               host_fill = host_fill + 1'b1;
               if (host_fill >= BLOCK_SIZE) close_host_block();
            end else begin
               stray = 1'b1;
            end
         end
         KIND_END: begin
            if (host_phase != PH_FILL) begin
               stray = 1'b1;
            end else if (host_fill == '0) begin
               host_phase = PH_DONE;
            end else begin
               host_ended = 1'b1;
               close_host_block();
            end
         end
         KIND_RX_BYTE: begin
            if (host_phase == PH_ACK_CMD || host_phase == PH_ACK_ADDR ||
                host_phase == PH_ACK_DATA) begin
               if (p.data_byte != ACK_BYTE) begin
                  host_phase = PH_ERROR;
               end else if (host_phase == PH_ACK_CMD) begin
                  host_sidx  = '0;
                  host_xor   = '0;
                  host_phase = PH_ADDR;
               end else if (host_phase == PH_ACK_ADDR) begin
                  host_phase = PH_LEN;
               end else begin
                  host_addr  = host_addr + 32'(host_fill);
                  host_fill  = '0;
                  host_sidx  = '0;
                  host_phase = host_ended ? PH_DONE : PH_FILL;
               end
            end else begin
               stray = 1'b1;
            end
         end
         KIND_TX_READY: begin
            r.tx_valid = 1'b1;
            case (host_phase)
               PH_CMD0: begin
                  r.tx_byte  = CMD_BYTE0;
                  host_phase = PH_CMD1;
               end
               PH_CMD1: begin
                  r.tx_byte  = CMD_BYTE1;
                  host_phase = PH_ACK_CMD;
               end
               PH_ADDR: begin
                  // big-endian address, then its XOR
                  if (host_sidx < CNT_W'(ADDR_BYTES)) begin
                     shifted   = host_addr >> (24 - 8 * int'(host_sidx));
                     r.tx_byte = shifted[7:0];
                     host_xor  = host_xor ^ r.tx_byte;
                     host_sidx = host_sidx + 1'b1;
                  end else begin
                     r.tx_byte  = host_xor;
                     host_phase = PH_ACK_ADDR;
                  end
               end
               PH_LEN: begin
                  len_m1     = host_fill - 1'b1;
                  r.tx_byte  = len_m1[7:0];
                  host_xor   = r.tx_byte;
                  host_sidx  = '0;
                  host_phase = PH_DATA;
               end
               PH_DATA: begin
                  r.tx_byte = host_buf[host_sidx[BUF_AW-1:0]];
                  host_xor  = host_xor ^ r.tx_byte;
                  host_sidx = host_sidx + 1'b1;
                  if (host_sidx >= host_fill) host_phase = PH_CSUM;
               end
               PH_CSUM: begin
                  r.tx_byte  = host_xor;
                  host_phase = PH_ACK_DATA;
               end
               default: r.tx_valid = 1'b0;
            endcase
         end
         default: stray = 1'b1;
      endcase
      r.want_data = (host_phase == PH_FILL);
      if (stray) r.status = STAT_UNEXPECTED;
      else begin
         case (host_phase)
            PH_IDLE:  r.status = STAT_IDLE;
            PH_DONE:  r.status = STAT_DONE;
            PH_ERROR: r.status = STAT_NACK;
            default:  r.status = STAT_BUSY;
         endcase
      end
      return r;
   endfunction

   // Receiver stall: long hold-off first, then random runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
         rsp_stall  <= 1'b1;
         stall_left <= run_length() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            $error("result beat with nothing awaited: %0h", rsp_payload);
            mismatch_count++;
         end else begin
            want_reply = awaited_replies.pop_front();
            if (rsp_payload.tx_valid !== want_reply.tx_valid) begin
               $error("tx_valid: expected %0h, got %0h", want_reply.tx_valid,
                      rsp_payload.tx_valid);
               mismatch_count++;
            end
            if (rsp_payload.tx_byte !== want_reply.tx_byte) begin
               $error("tx_byte: expected %0h, got %0h", want_reply.tx_byte,
                      rsp_payload.tx_byte);
               mismatch_count++;
            end
            if (rsp_payload.want_data !== want_reply.want_data) begin
               $error("want_data: expected %0h, got %0h", want_reply.want_data,
                      rsp_payload.want_data);
               mismatch_count++;
            end
            if (rsp_payload.status !== want_reply.status) begin
               $error("status: expected %0h, got %0h", want_reply.status,
                      rsp_payload.status);
               mismatch_count++;
            end
         end
      end
   end

   // Offer one request beat, wait for it to be taken, record its reply
   task automatic send_beat(input req_payload_type beat);
      int gap;
      gap = (idle_on && $urandom_range(0, 99) < 35) ? run_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_replies.push_back(predict_host_reply(beat));
      item_total++;
   endtask

   // Sender pause until every result beat is back
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   // A beat the host ignores in its present phase
   task automatic send_noise();
      logic [2:0] k;
      logic       live;
      k = 3'($urandom_range(KIND_DATA, KIND_RESERVED_MAX));
      live = ((k == KIND_DATA || k == KIND_END) && host_phase == PH_FILL)
          || (k == KIND_RX_BYTE && (host_phase == PH_ACK_CMD ||
              host_phase == PH_ACK_ADDR || host_phase == PH_ACK_DATA))
          || (k == KIND_TX_READY && (host_phase == PH_CMD0 || host_phase == PH_CMD1 ||
              host_phase == PH_ADDR || host_phase == PH_LEN ||
              host_phase == PH_DATA || host_phase == PH_CSUM));
      if (!live) send_beat({k, $urandom, 8'($urandom)});
   endtask

   // Sequence beat, with optional noise ahead and an optional restart
   task automatic issue(input logic [2:0] kind, input logic [31:0] addr,
                        input logic [7:0] data);
      if (noise_on && $urandom_range(0, 99) < 8) send_noise();
      if (abort_countdown > 0) begin
         abort_countdown--;
         if (abort_countdown == 0) begin
            send_beat({KIND_START, $urandom, 8'($urandom)});
         end
      end
      send_beat({kind, addr, data});
   endtask

   task automatic pull_bytes(input int n);
      repeat (n) issue(KIND_TX_READY, $urandom, 8'($urandom));
   endtask

   task automatic answer(input int nack_pct);
      logic [7:0] b;
      b = ACK_BYTE;
      if ($urandom_range(0, 99) < nack_pct) begin
         b = 8'($urandom);
         if (b == ACK_BYTE) b = ~b;
      end
      issue(KIND_RX_BYTE, $urandom, b);
   endtask

   // Header, address and data stages, each closed by the target's answer
   task automatic run_exchange(input int nack_pct);
      pull_bytes(2);
      answer(nack_pct);
      if (host_phase != PH_ERROR) begin
         pull_bytes(ADDR_BYTES + 1);
         answer(nack_pct);
         if (host_phase != PH_ERROR) begin
            pull_bytes(int'(host_fill) + 2);
            answer(nack_pct);
         end
      end
   endtask

   task automatic run_transfer(input logic [31:0] addr, input int full_blocks,
                               input int tail_len, input int nack_pct);
      int b;
      issue(KIND_START, addr, 8'($urandom));
      for (b = 0; b < full_blocks && host_phase != PH_ERROR; b++) begin
         repeat (BLOCK_SIZE) issue(KIND_DATA, $urandom, 8'($urandom));
         run_exchange(nack_pct);
      end
      if (host_phase != PH_ERROR) begin
         repeat (tail_len) issue(KIND_DATA, $urandom, 8'($urandom));
         issue(KIND_END, $urandom, 8'($urandom));
         if (tail_len > 0) run_exchange(nack_pct);
      end
      // idle pull shows the final status
      issue(KIND_TX_READY, $urandom, 8'($urandom));
   endtask

   // Items out of place before any start, reserved kind included
   task automatic test_misplaced_items();
      send_beat({KIND_TX_READY, 32'h0000_0000, 8'h00});
      send_beat({KIND_DATA, 32'hFFFF_FFFF, 8'hFF});
      send_beat({KIND_END, 32'h0000_0000, 8'h00});
      send_beat({KIND_RX_BYTE, 32'hFFFF_FFFF, ACK_BYTE});
      send_beat({KIND_RESERVED_MAX, 32'hFFFF_FFFF, 8'hFF});
   endtask

   // End of data on an empty buffer finishes at once
   task automatic test_empty_end();
      send_beat({KIND_START, 32'h0000_0000, 8'h00});
      send_beat({KIND_END, 32'h0000_0000, 8'h00});
      send_beat({KIND_TX_READY, 32'h0000_0000, 8'h00});
   endtask

   // Restart while filling, then a padded three-byte block at the top address
   task automatic test_short_block();
      send_beat({KIND_START, 32'h0000_1000, 8'h00});
      send_beat({KIND_DATA, 32'h0000_0000, 8'h5A});
      send_beat({KIND_START, 32'hFFFF_FFFF, 8'h00});
      send_beat({KIND_DATA, 32'h0000_0000, 8'h00});
      send_beat({KIND_DATA, 32'h0000_0000, 8'hFF});
      send_beat({KIND_DATA, 32'h0000_0000, 8'hA5});
      send_beat({KIND_END, 32'h0000_0000, 8'h00});
      run_exchange(0);
   endtask

   // Wrong answer to the command: error holds until the next start
   task automatic test_nack_abort();
      send_beat({KIND_START, 32'h8000_0001, 8'h00});
      send_beat({KIND_DATA, 32'h0000_0000, 8'h81});
      send_beat({KIND_END, 32'h0000_0000, 8'h00});
      pull_bytes(2);
      send_beat({KIND_RX_BYTE, 32'h0000_0000, 8'h1F});
      pull_bytes(1);
      send_beat({KIND_RX_BYTE, 32'h0000_0000, ACK_BYTE});
   endtask

   // Receiver holds off while beats keep coming, so the input backs up
   task automatic test_stall_pressure();
      hold_left <= 60;
      run_transfer($urandom, 0, 8, 0);
      drain_replies();
   endtask

   // Mostly well-formed transfers with random content, some broken or noisy
   task automatic test_random_transfers();
      int          n;
      int          r;
      int          full;
      int          tail;
      int          nack_pct;
      logic [31:0] addr;
      n = 0;
      while (item_total < ITEM_GOAL) begin
         idle_on  = ($urandom_range(0, 3) != 0);
         noise_on = 1'b1;
         case ($urandom_range(0, 3))
            0:       addr = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
            1:       addr = 32'($urandom_range(0, 255));
            default: addr = $urandom;
         endcase
         abort_countdown = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 20) : 0;
         nack_pct = ($urandom_range(0, 7) == 0) ? 30 : 0;
         full = 0;
         tail = $urandom_range(1, 12);
         r = $urandom_range(0, 99);
         if (n == 2) begin
            // full block crossing the top of the address space
            addr = 32'hFFFF_FFC0;
            full = 1;
            big_blocks++;
         end else if (r < 3 && big_blocks < BIG_MAX) begin
            tail = $urandom_range(BLOCK_SIZE - 4, BLOCK_SIZE - 1);
            big_blocks++;
         end else if (r < 10) begin
            tail = 0;
         end
         run_transfer(addr, full, tail, nack_pct);
         if (n % 8 == 7) drain_replies();
         n++;
      end
   endtask

   initial begin
      host_fill  = '0;
      host_addr  = '0;
      host_phase = PH_IDLE;
      host_sidx  = '0;
      host_xor   = '0;
      host_ended = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_misplaced_items();
      test_empty_end();
      test_short_block();
      test_nack_abort();
      test_stall_pressure();
      test_random_transfers();
      drain_replies();
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // Run limit
   initial begin
      #(RUN_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

endmodule
